### sv/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg: shared types and constants for the word stack
// Field widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

    localparam int ACT_W           = 2;
    localparam int POS_W           = 11;
    localparam int STAT_W          = 2;
    localparam int LANE_W          = 64;
    localparam int NUM_LANES       = 4;
    localparam int WORD_W          = LANE_W * NUM_LANES;
    localparam int DEF_STACK_DEPTH = 1024;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_WRITE = 2'd3
    } act_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_SMALL = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        FSM_IDLE   = 1'b0,
        FSM_RESULT = 1'b1
    } fsm_t;

endpackage

`default_nettype wire

### sv/wsp_ram.sv
// ----------------------------------------------------------------------------
// wsp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/word_stack_with_peek_poke_top.sv
// ----------------------------------------------------------------------------
// word_stack_with_peek_poke_top: operand stack of 256-bit words
// Flow: an accepted item takes the sequencer from idle to the result state,
//   which moves the registered word memory read into the output register
//   once any earlier result has been taken; out_valid is registered.
// A new item is taken only in idle, never while in the result state.
// Reset (rst_n, async, active low) clears depth, peak mark and handshake;
//   the word memory is not cleared, only entries below the depth are read.
// ----------------------------------------------------------------------------
`default_nettype none

module word_stack_with_peek_poke_top
    import wsp_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // operation channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [LANE_W-1:0] word_lane0,
    input  wire logic [LANE_W-1:0] word_lane1,
    input  wire logic [LANE_W-1:0] word_lane2,
    input  wire logic [LANE_W-1:0] word_lane3,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [LANE_W-1:0]      read_lane0,
    output logic [LANE_W-1:0]      read_lane1,
    output logic [LANE_W-1:0]      read_lane2,
    output logic [LANE_W-1:0]      read_lane3,
    output logic [STAT_W-1:0]      status,
    output logic [POS_W-1:0]       depth_now,
    output logic [POS_W-1:0]       peak_depth
);

    // address width, counter width (holds STACK_DEPTH itself), and a
    // compare width wide enough for both counter and position plus borrow
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // sequencer and stack pointer state
    fsm_t             state_reg, state_next;
    logic [CNT_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0] high_reg, high_next;
    logic             out_valid_reg, out_valid_next;

    // per-item result metadata, captured at the input transfer
    status_t          res_status_reg;
    logic [POS_W-1:0] res_depth_reg;
    logic [POS_W-1:0] res_peak_reg;
    logic             res_rd_reg;

    // output register
    logic [WORD_W-1:0] out_word_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [POS_W-1:0]  out_depth_reg;
    logic [POS_W-1:0]  out_peak_reg;

    // combinational
    logic              accept;
    logic              out_load;
    status_t           status_c;
    logic              rd_ok;
    logic [CMP_W-1:0]  pos_x, top_x, slot_x, top_next_x, high_next_x;
    logic [ADDR_W-1:0] slot;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [WORD_W-1:0] res_word;

    assign accept    = in_valid && in_ready;
    assign ram_wdata = {word_lane3, word_lane2, word_lane1, word_lane0};

    // distance below top maps to slot = top - 1 - position; only used when
    // position < top, so it always fits the address width
    assign pos_x       = CMP_W'(position);
    assign top_x       = CMP_W'(top_reg);
    assign slot_x      = top_x - CMP_W'(1) - pos_x;
    assign slot        = slot_x[ADDR_W-1:0];
    assign top_next_x  = CMP_W'(top_next);
    assign high_next_x = CMP_W'(high_next);

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        high_next      = high_reg;
        in_ready       = 1'b0;
        out_load       = 1'b0;
        status_c       = ST_OK;
        rd_ok          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = slot;

        unique case (state_reg)
            FSM_IDLE:
            begin
                // takes a new item even while the last result is unclaimed
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = FSM_RESULT;
                    unique case (act_t'(action))
                        ACT_PUSH:
                        begin
                            if (top_x >= CMP_W'(STACK_DEPTH))
                            begin
                                status_c = ST_OVER;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = top_reg[ADDR_W-1:0];
                                top_next  = top_reg + CNT_W'(1);
                                if (top_next > high_reg)
                                begin
                                    high_next = top_next;
                                end
                            end
                        end
                        ACT_POP:
                        begin
                            if (pos_x > top_x)
                            begin
                                status_c = ST_SMALL;
                            end
                            else
                            begin
                                top_next = CNT_W'(top_x - pos_x);
                            end
                        end
                        ACT_READ:
                        begin
                            if (pos_x >= top_x)
                            begin
                                status_c = ST_SMALL;
                            end
                            else
                            begin
                                ram_re = 1'b1;
                                rd_ok  = 1'b1;
                            end
                        end
                        ACT_WRITE:
                        begin
                            if (pos_x >= top_x)
                            begin
                                status_c = ST_SMALL;
                            end
                            else
                            begin
                                ram_we = 1'b1;
                            end
                        end
                    endcase
                end
            end
            FSM_RESULT:
            begin
                // read data is now out of the RAM; move into output register
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign res_word = res_rd_reg ? ram_rdata : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            top_reg       <= '0;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            high_reg      <= high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_status_reg <= status_c;
            res_depth_reg  <= top_next_x[POS_W-1:0];
            res_peak_reg   <= high_next_x[POS_W-1:0];
            res_rd_reg     <= rd_ok;
        end
        if (out_load)
        begin
            out_word_reg   <= res_word;
            out_status_reg <= res_status_reg;
            out_depth_reg  <= res_depth_reg;
            out_peak_reg   <= res_peak_reg;
        end
    end

    // word memory, all four lanes side by side
    wsp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign read_lane0 = out_word_reg[0*LANE_W +: LANE_W];
    assign read_lane1 = out_word_reg[1*LANE_W +: LANE_W];
    assign read_lane2 = out_word_reg[2*LANE_W +: LANE_W];
    assign read_lane3 = out_word_reg[3*LANE_W +: LANE_W];
    assign status     = out_status_reg;
    assign depth_now  = out_depth_reg;
    assign peak_depth = out_peak_reg;

`ifndef ASSERT_OFF
    // peak mark never falls below the current depth
    a_peak_ge_top: assert property (@(posedge clk) disable iff (!rst_n)
        high_reg >= top_reg)
        else $error("peak depth below current depth");

    // depth never exceeds the memory
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_x <= CMP_W'(STACK_DEPTH))
        else $error("stack depth beyond memory size");

    // a busy sequencer leaves the stack pointer alone
    a_busy_top_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FSM_RESULT |=> $stable(top_reg) && $stable(high_reg))
        else $error("stack pointer moved while busy");

    // a new result only ever comes from the result state
    a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == FSM_RESULT))
        else $error("result loaded outside result state");
`endif

endmodule

`default_nettype wire

### verif/word_stack_with_peek_poke_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_stack_with_peek_poke_top_tb: self-checking bench for the word stack
// A directed table covers the empty stack, edge positions and error status.
// The stack is then filled to overflow and drained, and mixed random
// operations follow. Each phase uses a different mix of sender idle cycles
// and receiver stalls. Every result is checked in order against an in-bench
// stack model or, for fixed table rows, against a hand-typed result.
// ----------------------------------------------------------------------------

module word_stack_with_peek_poke_top_tb;
    import wsp_pkg::*;

    localparam int STACK_DEPTH   = DEF_STACK_DEPTH;
    localparam int RANDOM_OPS    = 55;     // random operations per phase
    localparam int HANG_LIMIT    = 2000;   // cycles without any transfer
    localparam int DRAIN_CYCLES  = 8;      // settle time after the last expected result
    localparam int POS_MAX       = (1 << POS_W) - 1;

    localparam logic [WORD_W-1:0] ZERO_W = '0;
    localparam logic [WORD_W-1:0] ONES_W = '1;
    localparam logic [WORD_W-1:0] PAT_A  = {64'h0123456789abcdef, 64'hfedcba9876543210,
                                            64'h8000000000000001, 64'h5a5a5a5a5a5a5a5a};
    localparam logic [WORD_W-1:0] PAT_B  = {64'h00000000ffffffff, 64'haaaaaaaaaaaaaaaa,
                                            64'h7fffffffffffffff, 64'h0f0f0f0f0f0f0f0f};
    localparam logic [WORD_W-1:0] PAT_C  = {64'h3333333333333333, 64'h0000000000000001,
                                            64'hc3c3c3c3c3c3c3c3, 64'hffffffff00000000};

    // one result as seen on the result channel
    typedef struct packed {
        logic [WORD_W-1:0] rd;
        status_t           st;
        logic [POS_W-1:0]  depth;
        logic [POS_W-1:0]  peak;
    } stack_result_t;

    // one operation; 'fixed' rows carry a hand-typed result in 'want'
    typedef struct packed {
        act_t              act;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] word;
        logic              fixed;
        stack_result_t     want;
    } stack_op_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [ACT_W-1:0]  action = '0;
    logic [POS_W-1:0]  position = '0;
    logic [LANE_W-1:0] word_lane0 = '0;
    logic [LANE_W-1:0] word_lane1 = '0;
    logic [LANE_W-1:0] word_lane2 = '0;
    logic [LANE_W-1:0] word_lane3 = '0;

    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [LANE_W-1:0] read_lane0;
    logic [LANE_W-1:0] read_lane1;
    logic [LANE_W-1:0] read_lane2;
    logic [LANE_W-1:0] read_lane3;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  depth_now;
    logic [POS_W-1:0]  peak_depth;

    // stack model state: words, current depth, peak mark
    logic [WORD_W-1:0] model_words [STACK_DEPTH];
    int                model_depth = 0;
    int                model_peak  = 0;

    stack_result_t     pending_results [$];
    stack_op_t         directed_ops [$];
    stack_op_t         full_stack_ops [$];
    stack_op_t         cur_op;            // operation currently offered on the input

    int                sender_idle_pct = 0;
    int                recv_stall_pct  = 0;
    int                mismatches      = 0;
    int                quiet_cycles    = 0;

    word_stack_with_peek_poke_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .position   (position),
        .word_lane0 (word_lane0),
        .word_lane1 (word_lane1),
        .word_lane2 (word_lane2),
        .word_lane3 (word_lane3),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_lane0 (read_lane0),
        .read_lane1 (read_lane1),
        .read_lane2 (read_lane2),
        .read_lane3 (read_lane3),
        .status     (status),
        .depth_now  (depth_now),
        .peak_depth (peak_depth)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Stack model: applies one accepted operation and returns its result.
    // A failed operation leaves words, depth and peak untouched.
    // ------------------------------------------------------------------------
    function automatic stack_result_t apply_stack_op(input stack_op_t op);
        stack_result_t res;
        int            slot;
        res    = '0;
        res.st = ST_OK;
        case (op.act)
            ACT_PUSH:
            begin
                if (model_depth >= STACK_DEPTH)
                begin
                    res.st = ST_OVER;     // full: word dropped
                end
                else
                begin
                    model_words[model_depth] = op.word;
                    model_depth++;
                    if (model_depth > model_peak)
                        model_peak = model_depth;
                end
            end
            ACT_POP:
            begin
                // popping zero words is a legal no-op
                if (int'(op.pos) > model_depth)
                    res.st = ST_SMALL;
                else
                    model_depth -= int'(op.pos);
            end
            default:
            begin
                // read and write address from the top; position 0 is the top word
                if (int'(op.pos) >= model_depth)
                begin
                    res.st = ST_SMALL;
                end
                else
                begin
                    slot = model_depth - 1 - int'(op.pos);
                    if (op.act == ACT_READ)
                        res.rd = model_words[slot];
                    else
                        model_words[slot] = op.word;
                end
            end
        endcase
        res.depth = model_depth[POS_W-1:0];
        res.peak  = model_peak[POS_W-1:0];
        return res;
    endfunction

    function automatic void add_row(ref stack_op_t q[$], input act_t act, input int pos,
                                    input logic [WORD_W-1:0] word, input logic fixed,
                                    input status_t st, input int depth, input int peak,
                                    input logic [WORD_W-1:0] rd);
        stack_op_t op;
        op            = '0;
        op.act        = act;
        op.pos        = pos[POS_W-1:0];
        op.word       = word;
        op.fixed      = fixed;
        op.want.rd    = rd;
        op.want.st    = st;
        op.want.depth = depth[POS_W-1:0];
        op.want.peak  = peak[POS_W-1:0];
        q.insert(q.size(), op);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] w;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return ONES_W;
        if (pick < 18)
            return ZERO_W;
        for (int i = 0; i < WORD_W / 32; i++)
            w[i*32 +: 32] = $urandom;
        return w;
    endfunction

    // Random operation. While filling, mostly pushes with a few in-range
    // reads and writes; otherwise a mix with some out-of-range positions.
    function automatic stack_op_t pick_op(input bit filling);
        stack_op_t op;
        int        pick;
        int        hi;
        op      = '0;
        op.word = rand_word();
        if (filling)
        begin
            pick   = $urandom_range(99);
            op.act = (pick < 93 || model_depth == 0) ? ACT_PUSH :
                     (pick < 97) ? ACT_READ : ACT_WRITE;
            if (op.act != ACT_PUSH)
                op.pos = POS_W'($urandom_range(model_depth - 1));
            return op;
        end
        pick = $urandom_range(99);
        if (pick < 40)
            op.act = ACT_PUSH;
        else if (pick < 60)
            op.act = ACT_POP;
        else if (pick < 85)
            op.act = ACT_READ;
        else
            op.act = ACT_WRITE;
        if ($urandom_range(99) < 12)
        begin
            op.pos = POS_W'($urandom_range(POS_MAX));    // mostly out of range
        end
        else if (op.act == ACT_POP)
        begin
            op.pos = POS_W'($urandom_range((model_depth < 3) ? model_depth : 3));
        end
        else if (model_depth > 0)
        begin
            // favor words near the top, but reach the bottom too
            hi     = ($urandom_range(1) == 1 && model_depth > 4) ? 3 : model_depth - 1;
            op.pos = POS_W'($urandom_range(hi));
        end
        return op;
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: starts and ends at a falling edge. Idle cycles come
    // first, then the operation is held until the transfer.
    // ------------------------------------------------------------------------
    task automatic send_op(input stack_op_t op);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_op     = op;
        in_valid   <= 1'b1;
        action     <= op.act;
        position   <= op.pos;
        word_lane0 <= op.word[0*LANE_W +: LANE_W];
        word_lane1 <= op.word[1*LANE_W +: LANE_W];
        word_lane2 <= op.word[2*LANE_W +: LANE_W];
        word_lane3 <= op.word[3*LANE_W +: LANE_W];
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [LANE_W-1:0] got,
                                   input logic [LANE_W-1:0] want);
        $display("%0t ERROR %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // receiver: stalls at random, per cycle
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // ------------------------------------------------------------------------
    // Scoreboard. An input transfer is predicted before any output in the
    // same cycle is checked, so ordering within the edge does not matter.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        stack_result_t     want;
        stack_result_t     got;
        logic [WORD_W-1:0] got_word;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                want = apply_stack_op(cur_op);
                // hand-typed table rows override the model result
                pending_results.insert(pending_results.size(),
                                       cur_op.fixed ? cur_op.want : want);
            end
            if (out_valid && out_ready)
            begin
                got_word = {read_lane3, read_lane2, read_lane1, read_lane0};
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result, status", LANE_W'(status), '0);
                end
                else
                begin
                    got = pending_results.pop_front();
                    for (int l = 0; l < NUM_LANES; l++)
                        if (got_word[l*LANE_W +: LANE_W] !== got.rd[l*LANE_W +: LANE_W])
                            report_mismatch($sformatf("read_lane%0d", l),
                                            got_word[l*LANE_W +: LANE_W],
                                            got.rd[l*LANE_W +: LANE_W]);
                    if (status !== got.st)
                        report_mismatch("status", LANE_W'(status), LANE_W'(got.st));
                    if (depth_now !== got.depth)
                        report_mismatch("depth_now", LANE_W'(depth_now), LANE_W'(got.depth));
                    if (peak_depth !== got.peak)
                        report_mismatch("peak_depth", LANE_W'(peak_depth), LANE_W'(got.peak));
                end
            end
        end
    end

    // watchdog: a long stretch with no transfer on either side is a hang
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        // Directed table. From an empty stack: errors on pop, read and write, then
        // a small stack with reads, writes, edge positions and a partial pop.
        add_row(directed_ops, ACT_POP,   1,       ZERO_W, 1, ST_SMALL, 0, 0, ZERO_W);
        add_row(directed_ops, ACT_POP,   0,       ZERO_W, 1, ST_OK,    0, 0, ZERO_W);
        add_row(directed_ops, ACT_READ,  0,       ONES_W, 1, ST_SMALL, 0, 0, ZERO_W);
        add_row(directed_ops, ACT_WRITE, 0,       ONES_W, 1, ST_SMALL, 0, 0, ZERO_W);
        add_row(directed_ops, ACT_POP,   POS_MAX, ZERO_W, 1, ST_SMALL, 0, 0, ZERO_W);
        add_row(directed_ops, ACT_PUSH,  0,       ONES_W, 1, ST_OK,    1, 1, ZERO_W);
        add_row(directed_ops, ACT_READ,  0,       ZERO_W, 1, ST_OK,    1, 1, ONES_W);
        add_row(directed_ops, ACT_READ,  1,       ZERO_W, 1, ST_SMALL, 1, 1, ZERO_W);
        add_row(directed_ops, ACT_PUSH,  POS_MAX, ZERO_W, 1, ST_OK,    2, 2, ZERO_W);
        add_row(directed_ops, ACT_READ,  1,       ONES_W, 1, ST_OK,    2, 2, ONES_W);
        add_row(directed_ops, ACT_READ,  0,       ONES_W, 1, ST_OK,    2, 2, ZERO_W);
        add_row(directed_ops, ACT_PUSH,  0,       PAT_A,  0, ST_OK,    0, 0, ZERO_W);
        add_row(directed_ops, ACT_WRITE, 2,       PAT_B,  0, ST_OK,    0, 0, ZERO_W);
        add_row(directed_ops, ACT_READ,  2,       ZERO_W, 1, ST_OK,    3, 3, PAT_B);
        add_row(directed_ops, ACT_WRITE, 1024,    ONES_W, 1, ST_SMALL, 3, 3, ZERO_W);
        add_row(directed_ops, ACT_READ,  1024,    ZERO_W, 1, ST_SMALL, 3, 3, ZERO_W);
        add_row(directed_ops, ACT_WRITE, 3,       PAT_C,  1, ST_SMALL, 3, 3, ZERO_W);
        add_row(directed_ops, ACT_POP,   4,       ZERO_W, 1, ST_SMALL, 3, 3, ZERO_W);
        add_row(directed_ops, ACT_POP,   2,       ZERO_W, 1, ST_OK,    1, 3, ZERO_W);
        add_row(directed_ops, ACT_READ,  0,       ZERO_W, 1, ST_OK,    1, 3, PAT_B);
        add_row(directed_ops, ACT_PUSH,  0,       PAT_C,  0, ST_OK,    0, 0, ZERO_W);
        add_row(directed_ops, ACT_POP,   2,       ZERO_W, 1, ST_OK,    0, 3, ZERO_W);
        add_row(directed_ops, ACT_PUSH,  0,       PAT_A,  1, ST_OK,    1, 3, ZERO_W);

        // Full stack: overflowing pushes, bottom word access, pop of all.
        add_row(full_stack_ops, ACT_PUSH,  0,    ONES_W, 1, ST_OVER,  1024, 1024, ZERO_W);
        add_row(full_stack_ops, ACT_PUSH,  0,    PAT_C,  1, ST_OVER,  1024, 1024, ZERO_W);
        add_row(full_stack_ops, ACT_READ,  1023, ZERO_W, 0, ST_OK,    0,    0,    ZERO_W);
        add_row(full_stack_ops, ACT_READ,  1024, ZERO_W, 1, ST_SMALL, 1024, 1024, ZERO_W);
        add_row(full_stack_ops, ACT_WRITE, 1023, PAT_B,  0, ST_OK,    0,    0,    ZERO_W);
        add_row(full_stack_ops, ACT_READ,  1023, ZERO_W, 1, ST_OK,    1024, 1024, PAT_B);
        add_row(full_stack_ops, ACT_POP,   1025, ZERO_W, 1, ST_SMALL, 1024, 1024, ZERO_W);
        add_row(full_stack_ops, ACT_POP,   1024, ZERO_W, 1, ST_OK,    0,    1024, ZERO_W);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase 0: no idling on either side
        foreach (directed_ops[i])
            send_op(directed_ops[i]);
        while (model_depth < STACK_DEPTH)
            send_op(pick_op(1'b1));
        foreach (full_stack_ops[i])
            send_op(full_stack_ops[i]);
        repeat (RANDOM_OPS) send_op(pick_op(1'b0));

        // phase 1: sender mostly idle
        sender_idle_pct = 79;
        recv_stall_pct  = 0;
        repeat (RANDOM_OPS) send_op(pick_op(1'b0));

        // phase 2: receiver mostly stalled
        sender_idle_pct = 0;
        recv_stall_pct  = 79;
        repeat (RANDOM_OPS) send_op(pick_op(1'b0));

        // phase 3: both sides idle now and then
        sender_idle_pct = 31;
        recv_stall_pct  = 31;
        repeat (RANDOM_OPS) send_op(pick_op(1'b0));

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
